// ===== design/dit_pkg.sv =====
// Package for the dequantizing 8x8 inverse DCT: widths, control structs and the
// cosine weight table. Used by every module of the block; depends on nothing.
package dit_pkg;

  localparam int FRAC_BITS = 14;
  localparam int COEF_W    = 12;
  localparam int SCALE_W   = 8;
  localparam int PIX_W     = 16;
  localparam int X_W       = COEF_W + SCALE_W;
  localparam int WGT_W     = FRAC_BITS + 1;
  localparam int P1_W      = X_W + WGT_W;
  localparam int T_W       = P1_W + 3;
  localparam int TLO_W     = 18;
  localparam int THI_W     = T_W - TLO_W;
  localparam int P2_W      = T_W + WGT_W;
  localparam int ACC_W     = P2_W + 3;

  typedef logic signed [WGT_W-1:0] wgt_t;
  typedef logic signed [T_W-1:0]   tval_t;

  typedef struct packed {
    logic       v;
    logic [2:0] a;
    logic [2:0] k;
  } p1_ctl_t;

  typedef struct packed {
    logic       v;
    logic [2:0] k;
  } p2_ctl_t;

  localparam logic [31:0] HALF_COS_Q30 [9] = '{
    32'd536870912, 32'd526555088, 32'd496004047, 32'd446391849, 32'd379625062,
    32'd298269498, 32'd205451603, 32'd104738319, 32'd0
  };

  // Weight A[i][j] = c(i) * cos((2j+1) i pi / 16) with FRAC_BITS fraction bits.
  function automatic wgt_t weight(input logic [2:0] i, input logic [2:0] j);
    logic [6:0]  prod;
    logic [4:0]  m;
    logic        neg;
    logic [31:0] mag;
    logic [31:0] rnd;
    wgt_t        r;
    prod = 7'({3'b000, j, 1'b1}) * 7'({4'b0000, i});
    m    = prod[4:0];
    neg  = 1'b0;
    if (m > 5'd16) begin
      m = 5'(6'd32 - {1'b0, m});
    end
    if (m > 5'd8) begin
      m   = 5'd16 - m;
      neg = 1'b1;
    end
    if (i == 3'd0) begin
      mag = HALF_COS_Q30[4];
      neg = 1'b0;
    end else begin
      mag = HALF_COS_Q30[m[3:0]];
    end
    rnd = (mag + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    r   = rnd[WGT_W-1:0];
    return neg ? -r : r;
  endfunction

endpackage

// ===== design/dequant_idct_8x8.sv =====
// Top level of the dequantizing 8x8 inverse DCT: coefficient and transpose
// stores, sequencer and eight lanes per pass. Depends on dit_pkg and both lanes.

// The block takes eight coefficient rows, one per cycle while in_ready_o is
// high, and then computes the block with eight lanes working on the eight
// columns: the end of the column pass pipeline overlaps the start of the row
// pass. Each result row is computed by the row pass and held until it is
// transferred, and the next row starts in the cycle after the transfer.
// Throughput is set by each lane working through the eight terms of every
// sum one after another. The scales in force when the eighth row is
// transferred apply to the whole block.
module dequant_idct_8x8 import dit_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [SCALE_W-1:0]       cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [COEF_W-1:0] coef0_i,
  input  logic signed [COEF_W-1:0] coef1_i,
  input  logic signed [COEF_W-1:0] coef2_i,
  input  logic signed [COEF_W-1:0] coef3_i,
  input  logic signed [COEF_W-1:0] coef4_i,
  input  logic signed [COEF_W-1:0] coef5_i,
  input  logic signed [COEF_W-1:0] coef6_i,
  input  logic signed [COEF_W-1:0] coef7_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [PIX_W-1:0]  pix0_o,
  output logic signed [PIX_W-1:0]  pix1_o,
  output logic signed [PIX_W-1:0]  pix2_o,
  output logic signed [PIX_W-1:0]  pix3_o,
  output logic signed [PIX_W-1:0]  pix4_o,
  output logic signed [PIX_W-1:0]  pix5_o,
  output logic signed [PIX_W-1:0]  pix6_o,
  output logic signed [PIX_W-1:0]  pix7_o,
  output logic [2:0]               out_row_o,
  output logic                     block_end_o
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_COL  = 2'd1;
  localparam logic [1:0] ST_ROW  = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  localparam logic CFG_DC = 1'b0;
  localparam logic CFG_AC = 1'b1;

  logic [1:0]               state_q, state_d;
  logic [5:0]               cnt_q, cnt_d;
  logic [2:0]               row_count_q, row_count_d;
  logic [2:0]               out_row_q, out_row_d;
  logic [2:0]               t_wr_q;
  logic [SCALE_W-1:0]       dc_cfg_q, ac_cfg_q, dc_scale_q, ac_scale_q;
  logic                     out_valid_q;
  logic                     in_xfer, out_xfer;

  logic [8*COEF_W-1:0]      x_mem [8];
  logic [8*COEF_W-1:0]      x_rd_q;
  logic [8*COEF_W-1:0]      in_row;
  tval_t                    t_mem [8][8];
  tval_t                    t_rd_q [8];
  tval_t                    col_sum [8];
  p1_ctl_t                  p1_ctl_q;
  p2_ctl_t                  p2_ctl_q;
  logic [7:0]               col_done;
  logic [7:0]               row_done;
  logic signed [PIX_W-1:0]  pix [8];

  assign in_row   = {coef7_i, coef6_i, coef5_i, coef4_i,
                     coef3_i, coef2_i, coef1_i, coef0_i};
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_q && out_ready_i;
  assign in_ready_o = (state_q == ST_LOAD);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    row_count_d = row_count_q;
    out_row_d   = out_row_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          row_count_d = row_count_q + 3'd1;
          if (row_count_q == 3'd7) begin
            state_d = ST_COL;
            cnt_d   = '0;
          end
        end
      end
      ST_COL: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = ST_ROW;
          cnt_d   = '0;
        end
      end
      ST_ROW: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q[2:0] == 3'd7) begin
          state_d = ST_WAIT;
          cnt_d   = '0;
        end
      end
      ST_WAIT: begin
        if (out_xfer) begin
          out_row_d = out_row_q + 3'd1;
          state_d   = (out_row_q == 3'd7) ? ST_LOAD : ST_ROW;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      row_count_q <= '0;
      out_row_q   <= '0;
      t_wr_q      <= '0;
      dc_cfg_q    <= 8'd2;
      ac_cfg_q    <= 8'd16;
      out_valid_q <= 1'b0;
      p1_ctl_q    <= '0;
      p2_ctl_q    <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_count_q <= row_count_d;
      out_row_q   <= out_row_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DC: dc_cfg_q <= cfg_data_i;
          CFG_AC: ac_cfg_q <= cfg_data_i;
        endcase
      end
      if (col_done[0]) begin
        t_wr_q <= t_wr_q + 3'd1;
      end
      if (row_done[0]) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      p1_ctl_q <= '{v: (state_q == ST_COL), a: cnt_q[5:3], k: cnt_q[2:0]};
      p2_ctl_q <= '{v: (state_q == ST_ROW), k: cnt_q[2:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_mem[row_count_q] <= in_row;
      if (row_count_q == 3'd7) begin
        dc_scale_q <= dc_cfg_q;
        ac_scale_q <= ac_cfg_q;
      end
    end
    x_rd_q <= x_mem[cnt_q[2:0]];
    if (col_done[0]) begin
      for (int b = 0; b < 8; b++) begin
        t_mem[t_wr_q][b] <= col_sum[b];
      end
    end
    for (int b = 0; b < 8; b++) begin
      t_rd_q[b] <= t_mem[out_row_q][b];
    end
  end

  for (genvar b = 0; b < 8; b++) begin : g_lane
    dit_col_lane u_col (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .lane_idx_i (3'(b)),
      .ctl_i      (p1_ctl_q),
      .coef_i     (signed'(x_rd_q[b*COEF_W +: COEF_W])),
      .dc_scale_i (dc_scale_q),
      .ac_scale_i (ac_scale_q),
      .sum_o      (col_sum[b]),
      .done_o     (col_done[b])
    );
    dit_row_lane u_row (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .lane_idx_i (3'(b)),
      .ctl_i      (p2_ctl_q),
      .t_i        (t_rd_q[p2_ctl_q.k]),
      .pix_o      (pix[b]),
      .done_o     (row_done[b])
    );
  end

  assign out_valid_o = out_valid_q;
  assign pix0_o      = pix[0];
  assign pix1_o      = pix[1];
  assign pix2_o      = pix[2];
  assign pix3_o      = pix[3];
  assign pix4_o      = pix[4];
  assign pix5_o      = pix[5];
  assign pix6_o      = pix[6];
  assign pix7_o      = pix[7];
  assign out_row_o   = out_row_q;
  assign block_end_o = (out_row_q == 3'd7);

`ifndef SYNTHESIS
  a_lanes_col_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(col_done) == 0) || ($countones(col_done) == 8))
    else $error("column lanes finished out of step");
  a_lanes_row_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(row_done) == 0) || ($countones(row_done) == 8))
    else $error("row lanes finished out of step");
  a_no_load_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input taken while a result is pending");
  a_last_row_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && row_count_q == 3'd7) |=> !in_ready_o)
    else $error("input still taken after the eighth row");
  a_block_end_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && block_end_o) |=> in_ready_o)
    else $error("block not released after its last row");
`endif

endmodule

// ===== design/dit_col_lane.sv =====
// Column pass lane: dequantizes one coefficient per cycle and accumulates
// T[a][b] = sum_k A[k][a] * X[k][b]. Depends on dit_pkg.
module dit_col_lane import dit_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [2:0]                  lane_idx_i,
  input  p1_ctl_t                     ctl_i,
  input  logic signed [COEF_W-1:0]    coef_i,
  input  logic [SCALE_W-1:0]          dc_scale_i,
  input  logic [SCALE_W-1:0]          ac_scale_i,
  output tval_t                       sum_o,
  output logic                        done_o
);

  p1_ctl_t                  ctl2_q, ctl3_q;
  logic signed [X_W-1:0]    x_q;
  logic signed [P1_W-1:0]   p_q;
  tval_t                    acc_q;
  logic                     done_q;
  logic signed [SCALE_W:0]  scale;

  always_comb begin
    if (ctl_i.k == 3'd0 && lane_idx_i == 3'd0) begin
      scale = signed'({1'b0, dc_scale_i});
    end else begin
      scale = signed'({1'b0, ac_scale_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl2_q <= ctl_i;
      ctl3_q <= ctl2_q;
      done_q <= ctl3_q.v && (ctl3_q.k == 3'd7);
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= X_W'(coef_i) * X_W'(scale);
    p_q <= P1_W'(x_q) * P1_W'(weight(ctl2_q.k, ctl2_q.a));
    if (ctl3_q.v) begin
      if (ctl3_q.k == 3'd0) begin
        acc_q <= T_W'(p_q);
      end else begin
        acc_q <= acc_q + T_W'(p_q);
      end
    end
  end

  assign sum_o  = acc_q;
  assign done_o = done_q;

endmodule

// ===== design/dit_row_lane.sv =====
// Row pass lane: accumulates Y[a][b] = sum_k T[a][k] * A[k][b] with a split
// multiply, then rounds and saturates the sample. Depends on dit_pkg.
module dit_row_lane import dit_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [2:0]               lane_idx_i,
  input  p2_ctl_t                  ctl_i,
  input  tval_t                    t_i,
  output logic signed [PIX_W-1:0]  pix_o,
  output logic                     done_o
);

  p2_ctl_t                        ctl2_q;
  logic signed [THI_W+WGT_W-1:0]  ph_q;
  logic signed [TLO_W+WGT_W:0]    pl_q;
  logic signed [ACC_W-1:0]        acc_q;
  logic signed [ACC_W-1:0]        term;
  logic                           done_q;
  wgt_t                           w;
  logic [ACC_W-1:0]               mag;
  logic [ACC_W-1:0]               rnd;

  assign w = weight(ctl_i.k, lane_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl2_q <= ctl_i;
      done_q <= ctl2_q.v && (ctl2_q.k == 3'd7);
    end
  end

  assign term = (ACC_W'(ph_q) <<< TLO_W) + ACC_W'(pl_q);

  always_ff @(posedge clk_i) begin
    ph_q <= (THI_W+WGT_W)'(signed'(t_i[T_W-1:TLO_W])) * (THI_W+WGT_W)'(w);
    pl_q <= (TLO_W+WGT_W+1)'(signed'({1'b0, t_i[TLO_W-1:0]})) * (TLO_W+WGT_W+1)'(w);
    if (ctl2_q.v) begin
      if (ctl2_q.k == 3'd0) begin
        acc_q <= term;
      end else begin
        acc_q <= acc_q + term;
      end
    end
  end

  // Round half away from zero on the magnitude, then saturate.
  always_comb begin
    mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    rnd = (mag + (ACC_W'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
    if (!acc_q[ACC_W-1]) begin
      pix_o = (rnd > ACC_W'(32767)) ? 16'sh7fff : signed'(rnd[PIX_W-1:0]);
    end else begin
      pix_o = (rnd > ACC_W'(32768)) ? 16'sh8000 : signed'(-rnd[PIX_W-1:0]);
    end
  end

  assign done_o = done_q;

endmodule

// ===== verif/dequant_idct_8x8_tb.sv =====
// Testbench for the dequantizing 8x8 inverse DCT: directed and random coefficient
// blocks under several scale settings, checked against an in-bench predictor.
// Depends on dit_pkg and the dequant_idct_8x8 design.
`timescale 1ns / 1ps

module dequant_idct_8x8_tb;
  import dit_pkg::*;

  localparam int CFG_DC_SCALE = 0;
  localparam int CFG_AC_SCALE = 1;
  localparam int DRAIN_CYCLES = 250;

  typedef logic signed [COEF_W-1:0] coef_row_t [8];

  typedef struct {
    logic signed [PIX_W-1:0] pix [8];
    logic [2:0]              row;
    logic                    last;
  } pix_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic                    cfg_idx_i = 1'b0;
  logic [SCALE_W-1:0]      cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [COEF_W-1:0] coef_i [8] = '{default: '0};
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [PIX_W-1:0] pix_o [8];
  logic [2:0]              out_row_o;
  logic                    block_end_o;

  dequant_idct_8x8 dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .coef0_i(coef_i[0]), .coef1_i(coef_i[1]), .coef2_i(coef_i[2]), .coef3_i(coef_i[3]),
    .coef4_i(coef_i[4]), .coef5_i(coef_i[5]), .coef6_i(coef_i[6]), .coef7_i(coef_i[7]),
    .out_valid_o, .out_ready_i,
    .pix0_o(pix_o[0]), .pix1_o(pix_o[1]), .pix2_o(pix_o[2]), .pix3_o(pix_o[3]),
    .pix4_o(pix_o[4]), .pix5_o(pix_o[5]), .pix6_o(pix_o[6]), .pix7_o(pix_o[7]),
    .out_row_o, .block_end_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  localparam longint COS_HALF_Q30 [9] = '{
    536870912, 526555088, 496004047, 446391849, 379625062,
    298269498, 205451603, 104738319, 0
  };

  // Stimulus rows: a zero block, an all-maximum block and an all-minimum block.
  localparam logic signed [COEF_W-1:0] DIRECTED_ROWS [24][8] = '{
    '{8{12'sd0}}, '{8{12'sd0}}, '{8{12'sd0}}, '{8{12'sd0}},
    '{8{12'sd0}}, '{8{12'sd0}}, '{8{12'sd0}}, '{8{12'sd0}},
    '{8{12'sd2047}}, '{8{12'sd2047}}, '{8{12'sd2047}}, '{8{12'sd2047}},
    '{8{12'sd2047}}, '{8{12'sd2047}}, '{8{12'sd2047}}, '{8{12'sd2047}},
    '{8{-12'sd2048}}, '{8{-12'sd2048}}, '{8{-12'sd2048}}, '{8{-12'sd2048}},
    '{8{-12'sd2048}}, '{8{-12'sd2048}}, '{8{-12'sd2048}}, '{8{-12'sd2048}}
  };

  pix_row_t                 pix_expected [$];
  logic signed [COEF_W-1:0] blk_coefs [8][8];
  logic [7:0]               dc_gain = 8'd2;
  logic [7:0]               ac_gain = 8'd16;
  logic [2:0]               rows_seen = 3'd0;
  bit                       zero_block = 1'b0;
  bit                       quiet = 1'b0;
  int                       errors = 0;

  function automatic longint cos_weight(int i, int j);
    int m;
    longint r;
    if (i == 0) return (COS_HALF_Q30[4] + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    m = ((2 * j + 1) * i) % 32;
    if (m > 16) m = 32 - m;
    if (m > 8) begin
      r = (COS_HALF_Q30[16 - m] + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      return -r;
    end
    return (COS_HALF_Q30[m] + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  endfunction

  function automatic logic signed [PIX_W-1:0] round_saturate(longint acc);
    longint mag;
    mag = acc < 0 ? -acc : acc;
    mag = (mag + (64'sd1 << (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
    if (acc < 0) mag = -mag;
    if (mag > 32767) mag = 32767;
    if (mag < -32768) mag = -32768;
    return mag[PIX_W-1:0];
  endfunction

  task automatic predict_block();
    longint x [8][8];
    longint t [8][8];
    longint s;
    pix_row_t r;
    for (int a = 0; a < 8; a++)
      for (int b = 0; b < 8; b++)
        x[a][b] = longint'(blk_coefs[a][b]) * ((a == 0 && b == 0) ? dc_gain : ac_gain);
    for (int a = 0; a < 8; a++)
      for (int b = 0; b < 8; b++) begin
        s = 0;
        for (int k = 0; k < 8; k++) s += cos_weight(k, a) * x[k][b];
        t[a][b] = s;
      end
    for (int a = 0; a < 8; a++) begin
      for (int b = 0; b < 8; b++) begin
        s = 0;
        for (int k = 0; k < 8; k++) s += t[a][k] * cos_weight(k, b);
        r.pix[b] = round_saturate(s);
      end
      r.row  = a[2:0];
      r.last = (a == 7);
      pix_expected.push_back(r);
    end
  endtask

  always @(posedge clk_i) begin
    pix_row_t e;
    pix_row_t zr;
    if (in_valid_i && in_ready_o) begin
      for (int b = 0; b < 8; b++) blk_coefs[rows_seen][b] = coef_i[b];
      if (rows_seen == 3'd7) begin
        if (zero_block) begin
          for (int a = 0; a < 8; a++) begin
            zr.pix  = '{default: '0};
            zr.row  = a[2:0];
            zr.last = (a == 7);
            pix_expected.push_back(zr);
          end
        end else begin
          predict_block();
        end
      end
      rows_seen <= rows_seen + 3'd1;
    end
    if (out_valid_o && out_ready_i) begin
      if (pix_expected.size() == 0) begin
        $error("unexpected result row %0d", out_row_o);
        errors++;
      end else begin
        e = pix_expected.pop_front();
        for (int b = 0; b < 8; b++)
          if (pix_o[b] !== e.pix[b]) begin
            $error("pix%0d: expected %0d, got %0d", b, e.pix[b], pix_o[b]);
            errors++;
          end
        if (out_row_o !== e.row) begin
          $error("out_row: expected %0d, got %0d", e.row, out_row_o);
          errors++;
        end
        if (block_end_o !== e.last) begin
          $error("block_end: expected %0d, got %0d", e.last, block_end_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int run;
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        out_ready_i <= 1'b1;
      end else if (out_ready_i) begin
        run = $urandom_range(1, 30);
        repeat (run - 1) @(posedge clk_i);
        if (!quiet) out_ready_i <= 1'b0;
      end else begin
        run = $urandom_range(1, 18);
        repeat (run - 1) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_row(coef_row_t r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int b = 0; b < 8; b++) coef_i[b] <= r[b];
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pix_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_scales(logic [7:0] dc, logic [7:0] ac);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= 1'(CFG_DC_SCALE);
    cfg_data_i <= dc;
    @(posedge clk_i);
    dc_gain = dc;
    cfg_idx_i  <= 1'(CFG_AC_SCALE);
    cfg_data_i <= ac;
    @(posedge clk_i);
    ac_gain = ac;
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random_block();
    coef_row_t r;
    int mode;
    mode = $urandom_range(0, 3);
    for (int a = 0; a < 8; a++) begin
      for (int b = 0; b < 8; b++) begin
        case (mode)
          0: r[b] = 12'($urandom);
          1: r[b] = ($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'sd0;
          2: r[b] = $urandom_range(0, 1) ? 12'sd2047 : -12'sd2048;
          default: r[b] = $signed(12'($urandom_range(0, 64))) - 12'sd32;
        endcase
      end
      send_row(r);
    end
  endtask

  initial begin
    coef_row_t r;
    logic [7:0] gain_dc [6];
    logic [7:0] gain_ac [6];
    gain_dc = '{8'd255, 8'd1, 8'd0, 8'd255, 8'd7, 8'd128};
    gain_ac = '{8'd255, 8'd1, 8'd0, 8'd1, 8'd200, 8'd3};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int n = 0; n < 24; n++) begin
      zero_block = (n < 8);
      for (int b = 0; b < 8; b++) r[b] = DIRECTED_ROWS[n][b];
      send_row(r);
    end
    drain();
    zero_block = 1'b0;
    for (int p = 0; p < 6; p++) begin
      write_scales(gain_dc[p], gain_ac[p]);
      repeat (3) send_random_block();
      drain();
    end
    for (int p = 0; p < 4; p++) begin
      write_scales(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
      if (p == 3) quiet = 1'b1;
      repeat (4) send_random_block();
      drain();
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
